// File: design/fsmd_pkg.sv
// Shared types and constants for the 1 bpp Floyd-Steinberg dither block.
// No dependencies; used by every module of the block but fsmd_scale.
`timescale 1ns / 1ps

package fsmd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ERR_W     = 10;

    // configuration register indexes
    localparam logic [2:0] REG_ROW_WIDTH   = 3'd0;
    localparam logic [2:0] REG_BPP         = 3'd1;
    localparam logic [2:0] REG_RED_SHIFT   = 3'd2;
    localparam logic [2:0] REG_GREEN_SHIFT = 3'd3;
    localparam logic [2:0] REG_BLUE_SHIFT  = 3'd4;
    localparam logic [2:0] REG_RED_MAX     = 3'd5;
    localparam logic [2:0] REG_GREEN_MAX   = 3'd6;
    localparam logic [2:0] REG_BLUE_MAX    = 3'd7;

    typedef struct packed {
        logic [12:0] row_width;
        logic [2:0]  bytes_per_pixel;
        logic [4:0]  red_shift;
        logic [4:0]  green_shift;
        logic [4:0]  blue_shift;
        logic [15:0] red_max;
        logic [15:0] green_max;
        logic [15:0] blue_max;
    } cfg_t;

    // raw masked channel fields of one pixel
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        rect_start;
    } item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LUMA,
        ST_DITHER,
        ST_FLUSH,
        ST_EMIT
    } back_state_t;

endpackage

// File: design/fsmd_front.sv
// Front end: configuration registers, pixel intake, field extraction and a
// two-entry item queue toward the back end. Depends on fsmd_pkg.
`timescale 1ns / 1ps

module fsmd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output fsmd_pkg::cfg_t      cfg,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         pixel_word,
    input  logic                rect_start,
    output fsmd_pkg::item_t     item,
    output logic                item_empty,
    input  logic                item_pop
);

    fsmd_pkg::cfg_t  cfg_reg;
    fsmd_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [31:0]     word_m;
    logic [31:0]     red_sh, green_sh, blue_sh;
    fsmd_pkg::item_t new_item;
    logic            do_push, do_pop;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width       <= 13'd1;
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.red_shift       <= 5'd16;
            cfg_reg.green_shift     <= 5'd8;
            cfg_reg.blue_shift      <= 5'd0;
            cfg_reg.red_max         <= 16'd255;
            cfg_reg.green_max       <= 16'd255;
            cfg_reg.blue_max        <= 16'd255;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fsmd_pkg::REG_ROW_WIDTH:   cfg_reg.row_width       <= cfg_data[12:0];
                fsmd_pkg::REG_BPP:         cfg_reg.bytes_per_pixel <= cfg_data[2:0];
                fsmd_pkg::REG_RED_SHIFT:   cfg_reg.red_shift       <= cfg_data[4:0];
                fsmd_pkg::REG_GREEN_SHIFT: cfg_reg.green_shift     <= cfg_data[4:0];
                fsmd_pkg::REG_BLUE_SHIFT:  cfg_reg.blue_shift      <= cfg_data[4:0];
                fsmd_pkg::REG_RED_MAX:     cfg_reg.red_max         <= cfg_data;
                fsmd_pkg::REG_GREEN_MAX:   cfg_reg.green_max       <= cfg_data;
                fsmd_pkg::REG_BLUE_MAX:    cfg_reg.blue_max        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_reg.bytes_per_pixel == 3'd1)
            word_m = pixel_word & 32'h0000_00FF;
        else if (cfg_reg.bytes_per_pixel == 3'd2)
            word_m = pixel_word & 32'h0000_FFFF;
        else
            word_m = pixel_word;
        red_sh   = word_m >> cfg_reg.red_shift;
        green_sh = word_m >> cfg_reg.green_shift;
        blue_sh  = word_m >> cfg_reg.blue_shift;
        new_item.red        = red_sh[15:0] & cfg_reg.red_max;
        new_item.green      = green_sh[15:0] & cfg_reg.green_max;
        new_item.blue       = blue_sh[15:0] & cfg_reg.blue_max;
        new_item.rect_start = rect_start;
    end

    assign full       = (count_reg == 2'd2);
    assign item_empty = (count_reg == 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && !item_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: design/fsmd_scale.sv
// Channel scaler: field * 255 / max by restoring division, one quotient bit
// per cycle. Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module fsmd_scale (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] field,
    input  logic [15:0] max,
    output logic [7:0]  scaled,
    output logic        done
);

    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [7:0]  low_reg;
    logic [7:0]  q_reg;
    logic        done_reg;
    logic [23:0] num;
    logic [16:0] trial;
    logic        fits;

    // field <= max, so the quotient fits in 8 bits and num >> 8 < max
    assign num   = {field, 8'd0} - {8'd0, field};
    assign trial = {rem_reg, low_reg[7]};
    assign fits  = (trial >= {1'b0, max});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[23:8];
            low_reg <= num[7:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, max}) : trial[15:0];
            low_reg <= {low_reg[6:0], 1'b0};
            q_reg   <= {q_reg[6:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd7;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

    assign scaled = (max == 16'd0) ? 8'd0 : q_reg;
    assign done   = done_reg;

endmodule

// File: design/fsmd_back.sv
// Back end: scaling, luma, error diffusion over one row error memory, bit
// packing and a two-entry result queue. Depends on fsmd_pkg and fsmd_scale.
`timescale 1ns / 1ps

module fsmd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fsmd_pkg::cfg_t      cfg,
    input  fsmd_pkg::item_t     item,
    input  logic                item_empty,
    output logic                item_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          packed_byte,
    output logic                row_end
);

    localparam int CW = fsmd_pkg::COL_W;
    localparam int EW = fsmd_pkg::ERR_W;

    fsmd_pkg::back_state_t state_reg, state_next;

    fsmd_pkg::item_t   cur_reg, cur_next;
    logic [CW-1:0]     col_reg, col_next;
    logic              first_row_reg, first_row_next;
    logic signed [EW-1:0] right_reg, right_next;
    logic signed [EW-1:0] acc_prev_reg, acc_prev_next;
    logic signed [EW-1:0] acc_cur_reg, acc_cur_next;
    logic [7:0]        pack_reg, pack_next;
    logic              last_reg, last_next;
    logic [7:0]        luma_reg, luma_next;

    // row error memory: entry j holds the error due at column j of the next row
    logic [EW-1:0]     err_mem [fsmd_pkg::MAX_WIDTH];
    logic [EW-1:0]     rd_data_reg;
    logic              rd_en;
    logic              we;
    logic [CW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;

    logic              div_start;
    logic [7:0]        r_s, g_s, b_s;
    logic              r_done, g_done, b_done;

    logic [12:0]       w_eff;
    logic              last_c;
    logic [15:0]       luma_sum;
    logic signed [11:0] sum_w;
    logic [7:0]        sum_c;
    logic              bit_on;
    logic signed [11:0] err_x, t7, t5, t3;
    logic signed [11:0] e7, e5, e3, e1;

    fsmd_pkg::result_t oq_reg [2];
    logic              oq_wr_reg, oq_rd_reg;
    logic [1:0]        oq_count_reg;
    logic              oq_push, oq_pop;
    fsmd_pkg::result_t oq_in;

    fsmd_scale u_red   (.clk(clk), .rst_n(rst_n), .start(div_start), .field(cur_reg.red),
                        .max(cfg.red_max), .scaled(r_s), .done(r_done));
    fsmd_scale u_green (.clk(clk), .rst_n(rst_n), .start(div_start), .field(cur_reg.green),
                        .max(cfg.green_max), .scaled(g_s), .done(g_done));
    fsmd_scale u_blue  (.clk(clk), .rst_n(rst_n), .start(div_start), .field(cur_reg.blue),
                        .max(cfg.blue_max), .scaled(b_s), .done(b_done));

    always_comb
    begin
        if (cfg.row_width == 13'd0)
            w_eff = 13'd1;
        else if (cfg.row_width > 13'(fsmd_pkg::MAX_WIDTH))
            w_eff = 13'(fsmd_pkg::MAX_WIDTH);
        else
            w_eff = cfg.row_width;
        last_c = ({1'b0, col_reg} + 13'd1) >= w_eff;

        luma_sum = 16'(16'd77 * r_s) + 16'(16'd150 * g_s) + 16'(16'd29 * b_s);

        sum_w = $signed({4'd0, luma_reg}) + 12'(right_reg)
              + (first_row_reg ? 12'sd0 : 12'($signed(rd_data_reg)));
        if (sum_w < 12'sd0)
            sum_c = 8'd0;
        else if (sum_w > 12'sd255)
            sum_c = 8'd255;
        else
            sum_c = sum_w[7:0];
        bit_on = sum_c[7];
        err_x  = bit_on ? ($signed({4'd0, sum_c}) - 12'sd255) : $signed({4'd0, sum_c});
        t7 = (err_x <<< 3) - err_x;
        t5 = (err_x <<< 2) + err_x;
        t3 = (err_x <<< 1) + err_x;
        e7 = t7 >>> 4;
        e5 = t5 >>> 4;
        e3 = t3 >>> 4;
        e1 = err_x >>> 4;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        col_next       = col_reg;
        first_row_next = first_row_reg;
        right_next     = right_reg;
        acc_prev_next  = acc_prev_reg;
        acc_cur_next   = acc_cur_reg;
        pack_next      = pack_reg;
        last_next      = last_reg;
        luma_next      = luma_reg;
        item_pop       = 1'b0;
        div_start      = 1'b0;
        rd_en          = 1'b0;
        we             = 1'b0;
        wr_addr        = col_reg;
        wr_data        = acc_prev_reg;
        oq_push        = 1'b0;
        oq_in.packed_byte = pack_reg;
        oq_in.row_end     = last_reg;

        unique case (state_reg)
            fsmd_pkg::ST_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop = 1'b1;
                    cur_next = item;
                    if (item.rect_start)
                    begin
                        col_next       = '0;
                        first_row_next = 1'b1;
                        right_next     = '0;
                        pack_next      = '0;
                    end
                    state_next = fsmd_pkg::ST_SCALE;
                end
            end
            fsmd_pkg::ST_SCALE:
            begin
                // cur_reg is loaded, dividers start on entry
                div_start  = 1'b1;
                state_next = fsmd_pkg::ST_LUMA;
            end
            fsmd_pkg::ST_LUMA:
            begin
                if (r_done)
                begin
                    luma_next  = luma_sum[15:8];
                    rd_en      = 1'b1;
                    state_next = fsmd_pkg::ST_DITHER;
                end
            end
            fsmd_pkg::ST_DITHER:
            begin
                if (bit_on)
                    pack_next = pack_reg | (8'h80 >> col_reg[2:0]);
                right_next = EW'(e7);
                last_next  = last_c;
                if (col_reg != '0)
                begin
                    we      = 1'b1;
                    wr_addr = col_reg - CW'(1);
                    wr_data = EW'(acc_prev_reg + EW'(e3));
                    acc_prev_next = EW'(acc_cur_reg + EW'(e5));
                end
                else
                    acc_prev_next = EW'(e5);
                acc_cur_next = EW'(e1);
                if (last_c)
                    state_next = fsmd_pkg::ST_FLUSH;
                else if (col_reg[2:0] == 3'd7)
                    state_next = fsmd_pkg::ST_EMIT;
                else
                begin
                    col_next   = col_reg + CW'(1);
                    state_next = fsmd_pkg::ST_IDLE;
                end
            end
            fsmd_pkg::ST_FLUSH:
            begin
                // last column: its own entry gets no later lower-left term
                we         = 1'b1;
                wr_addr    = col_reg;
                wr_data    = acc_prev_reg;
                state_next = fsmd_pkg::ST_EMIT;
            end
            fsmd_pkg::ST_EMIT:
            begin
                if (oq_count_reg != 2'd2)
                begin
                    oq_push   = 1'b1;
                    pack_next = '0;
                    if (last_reg)
                    begin
                        col_next       = '0;
                        first_row_next = 1'b0;
                        right_next     = '0;
                    end
                    else
                        col_next = col_reg + CW'(1);
                    state_next = fsmd_pkg::ST_IDLE;
                end
            end
            default: state_next = fsmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsmd_pkg::ST_IDLE;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            right_reg     <= '0;
            pack_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            right_reg     <= right_next;
            pack_reg      <= pack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        acc_prev_reg <= acc_prev_next;
        acc_cur_reg  <= acc_cur_next;
        last_reg     <= last_next;
        luma_reg     <= luma_next;
    end

    // read of column j happens before any write to j in the same row
    always_ff @(posedge clk)
    begin
        if (we)
            err_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= err_mem[col_reg];
    end

    assign oq_pop      = pop && !empty;
    assign empty       = (oq_count_reg == 2'd0);
    assign packed_byte = oq_reg[oq_rd_reg].packed_byte;
    assign row_end     = oq_reg[oq_rd_reg].row_end;

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_reg] <= oq_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= ~oq_wr_reg;
            if (oq_pop)
                oq_rd_reg <= ~oq_rd_reg;
            if (oq_push && !oq_pop)
                oq_count_reg <= oq_count_reg + 2'd1;
            else if (oq_pop && !oq_push)
                oq_count_reg <= oq_count_reg - 2'd1;
        end
    end

    a_scalers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (r_done == g_done) && (g_done == b_done))
        else $error("channel scalers out of step");

    a_done_in_luma: assert property (@(posedge clk) disable iff (!rst_n)
        r_done |-> (state_reg == fsmd_pkg::ST_LUMA))
        else $error("scaler finished outside luma wait");

    a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> (oq_count_reg != 2'd2))
        else $error("result queue overflow");

    a_write_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (we && state_reg == fsmd_pkg::ST_DITHER) |-> (wr_addr != col_reg))
        else $error("error write hit the column being read");

endmodule

// File: design/floyd_steinberg_mono_dither_top.sv
// Top level of the 1 bpp Floyd-Steinberg dither block.
// Depends on fsmd_pkg, fsmd_front, fsmd_back (and fsmd_scale below it).
//
// Usage:
//   Pixels enter through a queue-style port: an item transfers when push is
//   high and full is low. rect_start on a pixel clears all diffused error and
//   restarts at column 0 of a first row.
//   Packed bytes leave through a queue-style port: the oldest byte sits on
//   packed_byte/row_end while empty is low and transfers when pop is high.
//   A byte comes out every eighth pixel of a row and on the last pixel of
//   each row (padded with zeros), row_end marking the latter.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
//   only while the block is idle. cfg_ready is always high.
// Timing:
//   Each pixel passes the back end states idle, scale, luma and dither, plus
//   emit when it completes a byte mid-row, or flush and emit at a row end;
//   luma waits for the bit-serial channel scalers. The byte is pushed into
//   the result queue at emit. The front queue holds two pixels, so full
//   rises while the back end works on earlier ones.
//   A stalled receiver fills the two-entry result queue; the back end then
//   waits at its emit step and intake backs up through full.
// Reset: queues empty, registers at their defaults, first row with no error.
`timescale 1ns / 1ps

module floyd_steinberg_mono_dither_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [31:0] pixel_word,
    input  logic        rect_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  packed_byte,
    output logic        row_end
);

    fsmd_pkg::cfg_t  cfg;
    fsmd_pkg::item_t item;
    logic            item_empty;
    logic            item_pop;

    fsmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .push       (push),
        .full       (full),
        .pixel_word (pixel_word),
        .rect_start (rect_start),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop)
    );

    fsmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item        (item),
        .item_empty  (item_empty),
        .item_pop    (item_pop),
        .empty       (empty),
        .pop         (pop),
        .packed_byte (packed_byte),
        .row_end     (row_end)
    );

endmodule

// File: dv/fsmd_checker.sv
// Checker for the 1 bpp Floyd-Steinberg dither block: watches the config,
// pixel and byte channels, predicts every packed byte and compares.
// Depends on fsmd_pkg.
`timescale 1ns / 1ps

module fsmd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] pixel_word,
    input  logic        rect_start,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  packed_byte,
    input  logic        row_end,
    output int          fail_count,
    output int          bytes_pending
);

    fsmd_pkg::cfg_t    cfg;
    int                col_pos;
    bit                top_row;
    int                cur_err [fsmd_pkg::MAX_WIDTH];
    int                nxt_err [fsmd_pkg::MAX_WIDTH];
    int                carry_err;
    logic [7:0]        bits_acc;
    fsmd_pkg::result_t expected_bytes [$];

    assign bytes_pending = expected_bytes.size();

    function automatic int scale_channel(logic [31:0] word, logic [4:0] sh, logic [15:0] mx);
        int v;
        v = int'((word >> sh) & {16'd0, mx});
        if (mx == 16'd0)
            return 0;
        if (mx != 16'd255)
            v = (v * 255) / int'(mx);
        return v;
    endfunction

    task automatic clear_errors();
        col_pos = 0;
        top_row = 1'b1;
        foreach (cur_err[i])
        begin
            cur_err[i] = 0;
            nxt_err[i] = 0;
        end
        carry_err = 0;
        bits_acc  = 8'd0;
    endtask

    task automatic dither_pixel(logic [31:0] raw, logic rs);
        logic [31:0]       word;
        int                w, col, luma, sum, err;
        bit                last;
        fsmd_pkg::result_t r;
        if (rs)
            clear_errors();
        w = int'(cfg.row_width);
        if (w == 0)
            w = 1;
        if (w > fsmd_pkg::MAX_WIDTH)
            w = fsmd_pkg::MAX_WIDTH;
        word = raw;
        if (cfg.bytes_per_pixel == 3'd1)
            word = word & 32'hFF;
        else if (cfg.bytes_per_pixel == 3'd2)
            word = word & 32'hFFFF;
        luma = (77 * scale_channel(word, cfg.red_shift, cfg.red_max)
              + 150 * scale_channel(word, cfg.green_shift, cfg.green_max)
              + 29 * scale_channel(word, cfg.blue_shift, cfg.blue_max)) >> 8;
        col = col_pos;
        if (col >= fsmd_pkg::MAX_WIDTH)
            col = fsmd_pkg::MAX_WIDTH - 1;
        last = (col + 1 >= w);
        sum = luma + carry_err + (top_row ? 0 : cur_err[col]);
        if (sum < 0)
            sum = 0;
        if (sum > 255)
            sum = 255;
        if (sum >= 128)
        begin
            bits_acc = bits_acc | (8'h80 >> (col % 8));
            err = sum - 255;
        end
        else
            err = sum;
        // error terms are floored, so arithmetic shifts
        carry_err = (err * 7) >>> 4;
        if (col > 0)
            nxt_err[col - 1] += (err * 3) >>> 4;
        if (col == 0)
            nxt_err[0] = (err * 5) >>> 4;
        else
            nxt_err[col] += (err * 5) >>> 4;
        if (!last)
            nxt_err[col + 1] = err >>> 4;
        if ((col % 8) == 7 || last)
        begin
            r.packed_byte = bits_acc;
            r.row_end     = last;
            expected_bytes.push_back(r);
            bits_acc = 8'd0;
            if (last)
            begin
                cur_err   = nxt_err;
                top_row   = 1'b0;
                carry_err = 0;
                col_pos   = 0;
            end
            else
                col_pos = col + 1;
        end
        else
            col_pos = col + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fsmd_pkg::result_t e;
        int                errs;
        errs = 0;
        if (!rst_n)
        begin
            cfg.row_width       <= 13'd1;
            cfg.bytes_per_pixel <= 3'd4;
            cfg.red_shift       <= 5'd16;
            cfg.green_shift     <= 5'd8;
            cfg.blue_shift      <= 5'd0;
            cfg.red_max         <= 16'd255;
            cfg.green_max       <= 16'd255;
            cfg.blue_max        <= 16'd255;
            clear_errors();
            expected_bytes.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fsmd_pkg::REG_ROW_WIDTH:   cfg.row_width       <= cfg_data[12:0];
                    fsmd_pkg::REG_BPP:         cfg.bytes_per_pixel <= cfg_data[2:0];
                    fsmd_pkg::REG_RED_SHIFT:   cfg.red_shift       <= cfg_data[4:0];
                    fsmd_pkg::REG_GREEN_SHIFT: cfg.green_shift     <= cfg_data[4:0];
                    fsmd_pkg::REG_BLUE_SHIFT:  cfg.blue_shift      <= cfg_data[4:0];
                    fsmd_pkg::REG_RED_MAX:     cfg.red_max         <= cfg_data;
                    fsmd_pkg::REG_GREEN_MAX:   cfg.green_max       <= cfg_data;
                    fsmd_pkg::REG_BLUE_MAX:    cfg.blue_max        <= cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                dither_pixel(pixel_word, rect_start);
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte %h row_end %b", $time, packed_byte, row_end);
                    errs++;
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (packed_byte !== e.packed_byte)
                    begin
                        $display("%0t: packed_byte expected %h actual %h",
                                 $time, e.packed_byte, packed_byte);
                        errs++;
                    end
                    if (row_end !== e.row_end)
                    begin
                        $display("%0t: row_end expected %b actual %b",
                                 $time, e.row_end, row_end);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the dither block testbench: clock, reset, config writes, pixel
// stimulus and byte draining with random gaps; verdict from fsmd_checker.
// Depends on fsmd_pkg, floyd_steinberg_mono_dither_top, fsmd_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        push;
    logic        full;
    logic [31:0] pixel_word;
    logic        rect_start;
    logic        empty;
    logic        pop;
    logic [7:0]  packed_byte;
    logic        row_end;
    int          fail_count;
    int          bytes_pending;
    int          cycles;
    int          pixels_sent;
    bit          busy_mode;

    floyd_steinberg_mono_dither_top dut (.*);

    fsmd_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int w, int bpp, int rs, int gs, int bs, int rm, int gm, int bm);
        cfg_write(fsmd_pkg::REG_ROW_WIDTH, 16'(w));
        cfg_write(fsmd_pkg::REG_BPP, 16'(bpp));
        cfg_write(fsmd_pkg::REG_RED_SHIFT, 16'(rs));
        cfg_write(fsmd_pkg::REG_GREEN_SHIFT, 16'(gs));
        cfg_write(fsmd_pkg::REG_BLUE_SHIFT, 16'(bs));
        cfg_write(fsmd_pkg::REG_RED_MAX, 16'(rm));
        cfg_write(fsmd_pkg::REG_GREEN_MAX, 16'(gm));
        cfg_write(fsmd_pkg::REG_BLUE_MAX, 16'(bm));
    endtask

    task automatic send_pixel(logic [31:0] word, logic rs);
        int gap;
        gap = busy_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        pixel_word <= word;
        rect_start <= rs;
        do @(posedge clk); while (full);
        pixels_sent++;
    endtask

    // hold off until every byte is out, then let queued pixels finish
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int pick_max();
        case ($urandom_range(0, 6))
            0: return 255;
            1: return 0;
            2: return 1;
            3: return 65535;
            4: return $urandom_range(1, 31);
            5: return 255;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    // byte side: random stalls, with stretches of back-to-back pops
    initial
    begin
        int stall;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = busy_mode ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int w, rows, n;
        cycles      = 0;
        pixels_sent = 0;
        busy_mode   = 1'b0;
        rst_n       = 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= fsmd_pkg::REG_ROW_WIDTH;
        cfg_data   <= 16'd0;
        push       <= 1'b0;
        pixel_word <= 32'd0;
        rect_start <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset defaults: one pixel per row
        send_pixel(32'h00000000, 1'b0);
        send_pixel(32'hFFFFFFFF, 1'b0);
        send_pixel(32'h00808080, 1'b0);
        drain();

        // byte-wide rows, black, white and mid gray
        set_all(8, 4, 16, 8, 0, 255, 255, 255);
        send_pixel(32'h00FFFFFF, 1'b1);
        for (int i = 0; i < 7; i++)
            send_pixel(32'h00000000, 1'b0);
        for (int i = 0; i < 8; i++)
            send_pixel(32'h007F7F7F + (i % 2), 1'b0);
        drain();

        // width 0 acts as 1; one-byte pixels; zero, unit and wide max
        set_all(0, 1, 31, 0, 3, 0, 1, 65535);
        send_pixel(32'hFFFFFFFF, 1'b1);
        send_pixel(32'h000000FE, 1'b0);
        send_pixel(32'h00000001, 1'b0);
        drain();

        // width above the maximum, then shrink in the middle of the row
        set_all(8191, 2, 0, 5, 10, 31, 63, 31);
        send_pixel(32'hFFFF0000, 1'b1);
        for (int i = 1; i < 20; i++)
            send_pixel($urandom(), 1'b0);
        drain();
        cfg_write(fsmd_pkg::REG_ROW_WIDTH, 16'd5);
        for (int i = 0; i < 6; i++)
            send_pixel($urandom(), 1'b0);
        drain();

        // random phases: full rows, rare mid-row restarts
        while (pixels_sent < 1560)
        begin
            busy_mode = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0)
                set_all(w, $urandom_range(0, 7), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 31),
                        pick_max(), pick_max(), pick_max());
            else
                set_all(w, 4, 16, 8, 0, 255, 255, 255);
            rows = $urandom_range(1, 6);
            n = rows * w + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0);
            for (int i = 0; i < n; i++)
                send_pixel(pick_word(), (i == 0) || ($urandom_range(0, 199) == 0));
            drain();
        end
        busy_mode = 1'b0;

        if (fail_count == 0 && bytes_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
